### sv/mbrtu_pkg.sv
// Shared constants, types and the CRC-16 byte update for the Modbus RTU sensor responder.
package mbrtu_pkg;

    localparam int RequestBytes = 8;
    localparam int CountW       = $clog2(RequestBytes);
    localparam int StartLoIdx   = 3;
    localparam int CrcLoIdx     = RequestBytes - 2;
    localparam int BodyMax      = 7;

    localparam logic [15:0] CrcInit         = 16'hFFFF;
    localparam logic [15:0] CrcPoly         = 16'hA001;
    localparam logic [7:0]  FuncReadHolding = 8'h03;
    localparam logic [7:0]  CountTwoRegs    = 8'h04;
    localparam logic [7:0]  CountOneReg     = 8'h02;
    localparam logic [7:0]  RegHumTemp      = 8'h00;
    localparam logic [7:0]  RegTemp         = 8'h01;

    typedef logic [CountW-1:0] t_count;
    typedef logic [3:0]        t_left;

    localparam t_left ReplyLongBytes  = 4'd9;
    localparam t_left ReplyShortBytes = 4'd7;
    localparam t_left CrcBytes        = 4'd2;

    typedef enum logic {
        CMD_RX_BYTE = 1'b0,
        CMD_SENSOR  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic        valid;
        logic        two_regs;
        logic [7:0]  addr;
        logic [15:0] hum;
        logic [14:0] temp;
    } t_reply_req;

    function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CrcPoly) : (x >> 1);
        end
        return x;
    endfunction

endpackage

### sv/mbrtu_rx_frame.sv
// Input register, request frame collection, CRC check and sensor value store.
module mbrtu_rx_frame (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_station_address,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic [7:0]            i_rx_byte,
    input  logic [15:0]           i_hum,
    input  logic signed [15:0]    i_temp,
    input  logic                  i_tx_idle,
    output mbrtu_pkg::t_reply_req o_req
);
    import mbrtu_pkg::*;

    localparam t_count LastIdx = t_count'(RequestBytes - 1);

    logic               r_in_valid;
    t_cmd               r_cmd;
    logic [7:0]         r_rx;
    logic [15:0]        r_hum;
    logic signed [15:0] r_temp;
    t_count             r_count;
    logic [15:0]        r_crc;
    logic [7:0]         r_frame [RequestBytes];
    logic [15:0]        r_hum_val;
    logic [14:0]        r_temp_val;

    logic        w_proc_en;
    logic        w_fire;
    logic        w_open;
    logic        w_take;
    logic        w_done;
    logic        w_good;
    logic [15:0] w_crc_base;
    logic [15:0] w_crc_fed;

    // a byte that may close a frame waits while a reply is still going out
    assign w_proc_en  = !(r_cmd == CMD_RX_BYTE && r_count == LastIdx && !i_tx_idle);
    assign w_fire     = r_in_valid && w_proc_en;
    assign o_ready    = !r_in_valid || w_proc_en;
    assign w_open     = (r_count != '0) || (r_rx == i_station_address);
    assign w_take     = w_fire && (r_cmd == CMD_RX_BYTE) && w_open;
    assign w_done     = (r_count == LastIdx);
    assign w_crc_base = (r_count == '0) ? CrcInit : r_crc;
    assign w_crc_fed  = crc_feed(w_crc_base, r_rx);
    assign w_good     = (r_frame[CrcLoIdx] == r_crc[7:0]) && (r_rx == r_crc[15:8]);

    always_comb begin
        o_req.valid    = w_take && w_done && w_good &&
                         (r_frame[StartLoIdx] == RegHumTemp || r_frame[StartLoIdx] == RegTemp);
        o_req.two_regs = (r_frame[StartLoIdx] == RegHumTemp);
        o_req.addr     = i_station_address;
        o_req.hum      = r_hum_val;
        o_req.temp     = r_temp_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_rx   <= i_rx_byte;
            r_hum  <= i_hum;
            r_temp <= i_temp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_crc      <= CrcInit;
            r_hum_val  <= '0;
            r_temp_val <= '0;
        end else if (w_fire) begin
            if (r_cmd == CMD_SENSOR) begin
                r_hum_val  <= r_hum;
                r_temp_val <= r_temp[15] ? 15'd0 : r_temp[14:0];
            end else if (w_open) begin
                r_count <= w_done ? t_count'(0) : r_count + t_count'(1);
                if (r_count < t_count'(CrcLoIdx)) begin
                    r_crc <= w_crc_fed;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_frame[r_count] <= r_rx;
        end
    end

    a_req_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.valid |-> i_tx_idle)
        else $error("reply raised while transmitter busy");

    a_sensor_keeps_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_cmd == CMD_SENSOR) |=> (r_count == $past(r_count)))
        else $error("sensor update disturbed frame count");

    a_reply_on_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.valid |=> (r_count == '0))
        else $error("frame count not cleared after complete frame");

endmodule

### sv/mbrtu_tx_reply.sv
// Reply byte sequencer with running CRC and registered output stage.
module mbrtu_tx_reply (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mbrtu_pkg::t_reply_req i_req,
    output logic                  o_idle,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_data,
    output logic                  o_last
);
    import mbrtu_pkg::*;

    t_left       r_left;
    logic [7:0]  r_sh [BodyMax];
    logic [15:0] r_crc;
    logic        r_m_valid;
    logic [7:0]  r_m_data;
    logic        r_m_last;

    logic w_out_free;
    logic w_emit;

    assign w_out_free = !r_m_valid || i_ready;
    assign w_emit     = w_out_free && (r_left != '0);
    assign o_idle     = (r_left == '0);
    assign o_valid    = r_m_valid;
    assign o_data     = r_m_data;
    assign o_last     = r_m_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_req.valid) begin
                r_left <= i_req.two_regs ? ReplyLongBytes : ReplyShortBytes;
            end else if (w_emit) begin
                r_left <= r_left - t_left'(1);
            end
            if (w_out_free) begin
                r_m_valid <= (r_left != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_crc   <= CrcInit;
            r_sh[0] <= i_req.addr;
            r_sh[1] <= FuncReadHolding;
            if (i_req.two_regs) begin
                r_sh[2] <= CountTwoRegs;
                r_sh[3] <= i_req.hum[15:8];
                r_sh[4] <= i_req.hum[7:0];
                r_sh[5] <= {1'b0, i_req.temp[14:8]};
                r_sh[6] <= i_req.temp[7:0];
            end else begin
                r_sh[2] <= CountOneReg;
                r_sh[3] <= {1'b0, i_req.temp[14:8]};
                r_sh[4] <= i_req.temp[7:0];
                r_sh[5] <= 8'h00;
                r_sh[6] <= 8'h00;
            end
        end else if (w_emit) begin
            for (int i = 0; i < BodyMax - 1; i++) begin
                r_sh[i] <= r_sh[i+1];
            end
            priority if (r_left > CrcBytes) begin
                r_crc    <= crc_feed(r_crc, r_sh[0]);
                r_m_data <= r_sh[0];
            end else if (r_left == CrcBytes) begin
                r_m_data <= r_crc[7:0];
            end else begin
                r_m_data <= r_crc[15:8];
            end
            r_m_last <= (r_left == t_left'(1));
        end
    end

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid |-> o_idle)
        else $error("reply loaded while previous reply in flight");

    a_last_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_left == t_left'(1)) |=> (r_m_valid && r_m_last))
        else $error("final reply byte not flagged last");

    a_body_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_left > CrcBytes) |=> (r_m_valid && !r_m_last))
        else $error("body byte flagged last");

endmodule

### sv/modbus_rtu_sensor_responder.sv
// Top level of the Modbus RTU sensor responder (read holding registers).
//
// Slave stream: tuser selects the item kind (0 = received serial byte,
// 1 = sensor update); tdata carries rx_byte, humidity and temperature tenths.
// Master stream: one item per reply byte, tlast on the CRC high byte.
// Configuration: i_cfg_wr_en writes the station address (reset value 1); the
// user must do so only while the block is idle; the block does not enforce it.
// Every input item passes through an input register and is processed from it,
// one item per cycle unless a closing byte waits. The eighth byte of a good
// request starts a reply of 9 or 7 bytes, which the sequencer builds with a
// running CRC and sends through its output register, one byte per cycle while
// the master side is ready. While a reply is in flight, further bytes and
// sensor updates are taken; only a byte that would close the next request
// waits until the sequencer has sent the previous reply.
// Reset clears the frame count, the CRC, the stored sensor values and both
// stream stages. A stalled master side holds its output register and the
// sequencer; the slave side keeps accepting until that closing byte arrives.
module modbus_rtu_sensor_responder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [7:0] rx_byte, [23:8] humidity_tenths,
                                       // [39:24] temperature_tenths
    input  logic        s_axis_tuser,  // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] tx_byte
    output logic        m_axis_tlast
);
    import mbrtu_pkg::*;

    logic [7:0] r_station_address;
    t_reply_req w_req;
    logic       w_tx_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_address <= 8'd1;
        end else if (i_cfg_wr_en) begin
            r_station_address <= i_cfg_wr_data;
        end
    end

    mbrtu_rx_frame u_rx (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_station_address (r_station_address),
        .i_valid           (s_axis_tvalid),
        .o_ready           (s_axis_tready),
        .i_cmd             (s_axis_tuser),
        .i_rx_byte         (s_axis_tdata[7:0]),
        .i_hum             (s_axis_tdata[23:8]),
        .i_temp            (s_axis_tdata[39:24]),
        .i_tx_idle         (w_tx_idle),
        .o_req             (w_req)
    );

    mbrtu_tx_reply u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_idle  (w_tx_idle),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

### dv/modbus_rtu_sensor_responder_checker.sv
// Checker for the Modbus RTU sensor responder: predicts reply bytes and compares them.
module modbus_rtu_sensor_responder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] rx_byte, [23:8] humidity, [39:24] temperature
    input  logic        s_axis_tuser,   // [0] command
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
    input  logic        m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output logic        o_in_frame
);
    timeunit 1ns;
    timeprecision 1ps;
    import mbrtu_pkg::*;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } t_reply_byte;

    t_reply_byte  reply_q[$];
    logic [7:0]   station_addr;
    logic [7:0]   request[RequestBytes];
    int unsigned  request_len;
    logic [15:0]  request_crc;
    logic [15:0]  humidity_tenths;
    logic [15:0]  temperature_tenths;
    int           fail_count = 0;

    // reflected CRC-16, one data bit at a time
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] acc;
        acc = crc;
        for (int i = 0; i < 8; i++) begin
            if (acc[0] ^ data[i]) begin
                acc = (acc >> 1) ^ CrcPoly;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic queue_reply(input logic [7:0] start_lo);
        logic [7:0]  body[$];
        logic [15:0] crc;
        body.push_back(station_addr);
        body.push_back(FuncReadHolding);
        if (start_lo == RegHumTemp) begin
            body.push_back(CountTwoRegs);
            body.push_back(humidity_tenths[15:8]);
            body.push_back(humidity_tenths[7:0]);
        end else begin
            body.push_back(CountOneReg);
        end
        body.push_back(temperature_tenths[15:8]);
        body.push_back(temperature_tenths[7:0]);
        crc = CrcInit;
        foreach (body[i]) begin
            crc = crc16_step(crc, body[i]);
            reply_q.push_back({body[i], 1'b0});
        end
        reply_q.push_back({crc[7:0], 1'b0});
        reply_q.push_back({crc[15:8], 1'b1});
    endtask

    always @(posedge i_clk) begin
        t_reply_byte want;
        if (!i_rst_n) begin
            reply_q.delete();
            station_addr       = 8'd1;
            request_len        = 0;
            request_crc        = CrcInit;
            humidity_tenths    = '0;
            temperature_tenths = '0;
        end else begin
            if (i_cfg_wr_en) begin
                station_addr = i_cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (t_cmd'(s_axis_tuser) == CMD_SENSOR) begin
                    humidity_tenths    = s_axis_tdata[23:8];
                    temperature_tenths = s_axis_tdata[39] ? 16'h0000 : s_axis_tdata[39:24];
                end else if (request_len != 0 || s_axis_tdata[7:0] == station_addr) begin
                    if (request_len == 0) begin
                        request_crc = CrcInit;
                    end
                    request[request_len] = s_axis_tdata[7:0];
                    if (request_len < CrcLoIdx) begin
                        request_crc = crc16_step(request_crc, s_axis_tdata[7:0]);
                    end
                    request_len++;
                    if (request_len == RequestBytes) begin
                        request_len = 0;
                        if ({request[CrcLoIdx + 1], request[CrcLoIdx]} == request_crc &&
                            (request[StartLoIdx] == RegHumTemp ||
                             request[StartLoIdx] == RegTemp)) begin
                            queue_reply(request[StartLoIdx]);
                        end
                    end
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (reply_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected reply byte %02h last %b",
                                              m_axis_tdata, m_axis_tlast));
                end else begin
                    want = reply_q.pop_front();
                    if (m_axis_tdata !== want.tx_byte) begin
                        report_mismatch($sformatf("tx_byte got %02h want %02h",
                                                  m_axis_tdata, want.tx_byte));
                    end
                    if (m_axis_tlast !== want.last_byte) begin
                        report_mismatch($sformatf("last_byte got %b want %b (byte %02h)",
                                                  m_axis_tlast, want.last_byte, want.tx_byte));
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= reply_q.size();
        o_in_frame   <= (request_len != 0);
    end

endmodule

### dv/modbus_rtu_sensor_responder_test.sv
// Testbench top for the Modbus RTU sensor responder: stimulus, receiver stalls, verdict.
module modbus_rtu_sensor_responder_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mbrtu_pkg::*;

    localparam int SettleCycles = 8;
    localparam int PhaseItems   = 22;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_SLOW
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [7:0]  i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // [7:0] rx_byte, [23:8] humidity, [39:24] temperature
    logic        s_axis_tuser = 1'b0; // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [7:0] tx_byte
    logic        m_axis_tlast;

    int          fail_count;
    int          pending;
    logic        in_frame;

    logic [7:0]  station = 8'd1;
    int unsigned burst_left = 0;
    int unsigned items_sent = 0;
    t_rx_mode    rx_mode = RX_OPEN;
    int unsigned rx_mode_cycles = 0;

    modbus_rtu_sensor_responder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    modbus_rtu_sensor_responder_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_in_frame    (in_frame)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // receiver: switches at random between stall patterns
    always @(posedge i_clk) begin
        if (rx_mode_cycles == 0) begin
            rx_mode        <= t_rx_mode'($urandom_range(RX_SLOW));
            rx_mode_cycles <= $urandom_range(16, 80);
        end else begin
            rx_mode_cycles <= rx_mode_cycles - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(1));
            RX_SPARSE: m_axis_tready <= ($urandom_range(3) == 0);
            default:   m_axis_tready <= (rx_mode_cycles % 8 == 0);
        endcase
    end

    task automatic push_item(input t_cmd cmd, input logic [7:0] rx,
                             input logic [15:0] hum, input logic [15:0] temp);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(7) == 0) ? 24 : 5)) @(posedge i_clk);
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {temp, hum, rx};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_byte(input logic [7:0] b);
        push_item(CMD_RX_BYTE, b, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_sensor(input logic [15:0] hum, input logic [15:0] temp);
        push_item(CMD_SENSOR, 8'($urandom), hum, temp);
        items_sent++;
    endtask

    task automatic send_random_sensor();
        logic [15:0] temp;
        case ($urandom_range(3))
            0:       temp = 16'h8000 | 16'($urandom);
            1:       temp = 16'($urandom_range(16'h7FFF));
            2:       temp = ($urandom_range(1) == 0) ? 16'h7FFF : 16'h8000;
            default: temp = 16'($urandom);
        endcase
        send_sensor(($urandom_range(5) == 0) ? 16'hFFFF : 16'($urandom), temp);
    endtask

    task automatic send_request(input logic [7:0] func, input logic [7:0] start_lo,
                                input bit bad_crc, input bit mid_update);
        logic [7:0]  frame[RequestBytes];
        logic [15:0] crc;
        int unsigned split;
        frame[0] = station;
        frame[1] = func;
        frame[2] = 8'($urandom);
        frame[3] = start_lo;
        frame[4] = 8'($urandom);
        frame[5] = 8'($urandom);
        crc = CrcInit;
        for (int i = 0; i < CrcLoIdx; i++) begin
            crc = crc_feed(crc, frame[i]);
        end
        if (bad_crc) begin
            crc ^= 16'd1 << $urandom_range(15);
        end
        frame[CrcLoIdx]     = crc[7:0];
        frame[CrcLoIdx + 1] = crc[15:8];
        split = mid_update ? $urandom_range(1, RequestBytes - 1) : RequestBytes;
        for (int i = 0; i < RequestBytes; i++) begin
            if (i == split) begin
                send_random_sensor();
            end
            send_byte(frame[i]);
        end
        items_sent += RequestBytes;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // close any open frame, then wait out all replies
    task automatic go_idle();
        settle();
        while (in_frame) begin
            send_byte(8'($urandom));
            settle();
        end
    endtask

    task automatic set_station(input logic [7:0] addr);
        go_idle();
        station       = addr;
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= addr;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] pick_start_lo();
        case ($urandom_range(9))
            0:       return 8'($urandom);
            1, 2, 3,
            4:       return RegHumTemp;
            default: return RegTemp;
        endcase
    endfunction

    function automatic logic [7:0] pick_func();
        return ($urandom_range(3) == 0) ? 8'($urandom) : FuncReadHolding;
    endfunction

    task automatic random_traffic(input int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                send_request(pick_func(), pick_start_lo(), 1'b0, $urandom_range(4) == 0);
            end else if (pick < 67) begin
                send_request(pick_func(), pick_start_lo(), 1'b1, $urandom_range(4) == 0);
            end else if (pick < 80) begin
                send_random_sensor();
            end else if (pick < 90) begin
                send_byte(8'($urandom));
                items_sent++;
            end else if (pick < 96) begin
                // truncated frame; the bytes sent next complete it
                send_byte(station);
                items_sent++;
                repeat ($urandom_range(1, RequestBytes - 2)) begin
                    send_byte(8'($urandom));
                    items_sent++;
                end
            end else begin
                settle();
            end
        end
    endtask

    initial begin
        #400_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, unchecked function code, sensor update mid-frame, unsupported start register
        send_sensor(16'hFFFF, 16'h7FFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_request(8'hFF, RegHumTemp, 1'b0, 1'b0);
        send_sensor(16'h0000, 16'h8000);
        send_request(FuncReadHolding, RegTemp, 1'b0, 1'b1);
        send_sensor(16'd655, 16'hFFFF);
        send_request(FuncReadHolding, 8'h02, 1'b0, 1'b0);
        settle();

        random_traffic(PhaseItems);
        set_station(8'hFF);
        random_traffic(PhaseItems);
        set_station(8'h00);
        random_traffic(PhaseItems);
        set_station(8'($urandom_range(2, 254)));
        random_traffic(PhaseItems);

        go_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
